### src/uff_pkg.sv
package uff_pkg;

    // frame geometry
    localparam int unsigned MAX_FRAME_BYTES = 65536;
    localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [POS_W-1:0] MAX_POS    = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] IP_BASE    = POS_W'(14);
    localparam logic [POS_W-1:0] PROTO_POS  = POS_W'(23);
    localparam logic [POS_W-1:0] SRC_IP_POS = POS_W'(26);
    localparam logic [POS_W-1:0] DST_IP_POS = POS_W'(30);

    localparam logic [7:0] UDP_PROTO = 8'd17;
    localparam logic [3:0] MIN_IHL   = 4'd5;

    // filter enable bits
    localparam int unsigned FLT_SRC_IP   = 0;
    localparam int unsigned FLT_DST_IP   = 1;
    localparam int unsigned FLT_SRC_PORT = 2;
    localparam int unsigned FLT_DST_PORT = 3;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned TOTAL_W = 48;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        REG_FILTER_ENABLES    = 3'd0,
        REG_MATCH_SOURCE_IP   = 3'd1,
        REG_MATCH_DEST_IP     = 3'd2,
        REG_MATCH_SOURCE_PORT = 3'd3,
        REG_MATCH_DEST_PORT   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_STATS   = 1'b1
    } t_kind;

    // one job handed from the parser to the counters
    typedef struct packed {
        t_kind            kind;
        logic             is_udp;
        logic             counted;
        logic [POS_W-1:0] frame_length;
    } t_job;

endpackage

### src/uff_front.sv
module uff_front
    import uff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_accept,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_push,
    output t_job        o_job
);

    logic [3:0]       r_enables;
    logic [31:0]      r_src_ip;
    logic [31:0]      r_dst_ip;
    logic [15:0]      r_src_port;
    logic [15:0]      r_dst_port;

    logic [POS_W-1:0] r_pos;
    logic [3:0]       r_hw;
    logic             r_udp;
    logic [3:0]       r_match;
    logic [3:0]       r_seen;

    logic [POS_W-1:0] n_pos;
    logic [3:0]       n_hw;
    logic             n_udp;
    logic [3:0]       n_match;
    logic [3:0]       n_seen;

    logic             byte_acc;
    logic             frame_end;
    logic [POS_W-1:0] port_base;
    logic             udp_ok;
    logic             pass;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enables  <= '0;
            r_src_ip   <= '0;
            r_dst_ip   <= '0;
            r_src_port <= '0;
            r_dst_port <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_FILTER_ENABLES:    r_enables  <= i_cfg_data[3:0];
                REG_MATCH_SOURCE_IP:   r_src_ip   <= i_cfg_data;
                REG_MATCH_DEST_IP:     r_dst_ip   <= i_cfg_data;
                REG_MATCH_SOURCE_PORT: r_src_port <= i_cfg_data[15:0];
                REG_MATCH_DEST_PORT:   r_dst_port <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign byte_acc  = i_accept && (i_action == 1'b0);
    assign frame_end = byte_acc && i_last_byte;
    assign port_base = IP_BASE + POS_W'({r_hw, 2'b00});

    always_comb begin
        n_pos   = r_pos;
        n_hw    = r_hw;
        n_udp   = r_udp;
        n_match = r_match;
        n_seen  = r_seen;
        if (byte_acc && (r_pos < MAX_POS)) begin
            if (r_pos == IP_BASE) begin
                n_hw = i_data_byte[3:0];
            end
            if (r_pos == PROTO_POS) begin
                n_udp = (i_data_byte == UDP_PROTO);
            end
            for (int k = 0; k < 4; k++) begin
                if (r_pos == SRC_IP_POS + POS_W'(k)) begin
                    if (r_src_ip[8*(3-k) +: 8] != i_data_byte) begin
                        n_match[FLT_SRC_IP] = 1'b0;
                    end
                    if (k == 3) begin
                        n_seen[FLT_SRC_IP] = 1'b1;
                    end
                end
                if (r_pos == DST_IP_POS + POS_W'(k)) begin
                    if (r_dst_ip[8*(3-k) +: 8] != i_data_byte) begin
                        n_match[FLT_DST_IP] = 1'b0;
                    end
                    if (k == 3) begin
                        n_seen[FLT_DST_IP] = 1'b1;
                    end
                end
            end
            // udp ports follow the ip header, only once ihl is known and sane
            if ((r_pos > IP_BASE) && (r_hw >= MIN_IHL)) begin
                for (int k = 0; k < 2; k++) begin
                    if (r_pos == port_base + POS_W'(k)) begin
                        if (r_src_port[8*(1-k) +: 8] != i_data_byte) begin
                            n_match[FLT_SRC_PORT] = 1'b0;
                        end
                        if (k == 1) begin
                            n_seen[FLT_SRC_PORT] = 1'b1;
                        end
                    end
                    if (r_pos == port_base + POS_W'(k + 2)) begin
                        if (r_dst_port[8*(1-k) +: 8] != i_data_byte) begin
                            n_match[FLT_DST_PORT] = 1'b0;
                        end
                        if (k == 1) begin
                            n_seen[FLT_DST_PORT] = 1'b1;
                        end
                    end
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    assign udp_ok = n_udp && (n_hw >= MIN_IHL);
    assign pass   = udp_ok && ((r_enables & n_seen & n_match) == r_enables);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_end) begin
            r_pos   <= '0;
            r_hw    <= '0;
            r_udp   <= 1'b0;
            r_match <= '1;
            r_seen  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hw    <= n_hw;
            r_udp   <= n_udp;
            r_match <= n_match;
            r_seen  <= n_seen;
        end
    end

    assign o_push = (i_accept && (i_action == 1'b1)) || frame_end;

    always_comb begin
        if (i_action == 1'b1) begin
            o_job.kind         = KIND_STATS;
            o_job.is_udp       = 1'b0;
            o_job.counted      = 1'b0;
            o_job.frame_length = '0;
        end else begin
            o_job.kind         = KIND_VERDICT;
            o_job.is_udp       = udp_ok;
            o_job.counted      = pass;
            o_job.frame_length = n_pos;
        end
    end

endmodule

### src/uff_queue.sv
module uff_queue
    import uff_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd];

endmodule

### src/uff_back.sv
module uff_back
    import uff_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_job               i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic               o_is_udp,
    output logic               o_counted,
    output logic [POS_W-1:0]   o_frame_length,
    output logic [CNT_W-1:0]   o_packet_count,
    output logic [TOTAL_W-1:0] o_byte_total
);

    logic [CNT_W-1:0]   r_count;
    logic [TOTAL_W-1:0] r_total;
    logic [CNT_W-1:0]   n_count;
    logic [TOTAL_W-1:0] n_total;
    logic [TOTAL_W:0]   sum;
    logic               bump;

    logic               r_valid;
    t_job               r_job;
    logic [CNT_W-1:0]   r_out_count;
    logic [TOTAL_W-1:0] r_out_total;

    assign o_pop = !i_empty && (!r_valid || !i_stall);
    assign bump  = o_pop && (i_head.kind == KIND_VERDICT) && i_head.counted;
    assign sum   = {1'b0, r_total} + (TOTAL_W+1)'(i_head.frame_length);

    always_comb begin
        n_count = r_count;
        n_total = r_total;
        if (bump) begin
            if (r_count != '1) begin
                n_count = r_count + CNT_W'(1);
            end
            n_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job       <= i_head;
            r_out_count <= n_count;
            r_out_total <= n_total;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_job.kind;
    assign o_is_udp       = r_job.is_udp;
    assign o_counted      = r_job.counted;
    assign o_frame_length = r_job.frame_length;
    assign o_packet_count = r_out_count;
    assign o_byte_total   = r_out_total;

endmodule

### src/udp_frame_filter_statistics.sv
// udp frame filter and statistics: one beat per cycle in while the job queue has room,
// at most one result beat per cycle out while i_out_stall is low; a final frame byte
// or a query gives its result through the parser, the 4-deep job queue and the
// counter/output register; the input stalls only while the job queue is full
// reset: synchronous active-low i_rst_n clears counters, frame state and filter registers
module udp_frame_filter_statistics
    import uff_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic               o_is_udp,
    output logic               o_counted,
    output logic [POS_W-1:0]   o_frame_length,
    output logic [CNT_W-1:0]   o_packet_count,
    output logic [TOTAL_W-1:0] o_byte_total
);

    logic accept;
    logic push;
    t_job push_job;
    logic q_full;
    logic q_empty;
    logic pop;
    t_job head;

    // the parser takes a beat whenever the queue has room
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // front: byte position tracking, header decode, per-byte filter compare
    uff_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_job       (push_job)
    );

    // short job queue so parser and counters stall independently
    uff_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_head     (head)
    );

    // back: saturating counters and the output register
    uff_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_kind         (o_kind),
        .o_is_udp       (o_is_udp),
        .o_counted      (o_counted),
        .o_frame_length (o_frame_length),
        .o_packet_count (o_packet_count),
        .o_byte_total   (o_byte_total)
    );

endmodule
